// File: design/spmf_pkg.sv
// shared constants, types and codes for the strict-priority multi-level queue
// no dependencies; every design file refers to it by scoped names
package spmf_pkg;

   // queue geometry
   localparam int LEVELS = 8;
   localparam int DEPTH = 16;

   localparam int LVL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int ADDR_W = (LEVELS * DEPTH > 1) ? $clog2(LEVELS * DEPTH) : 1;

   // payload widths
   localparam int DATA_W = 32;
   localparam int PRI_W = 8;
   localparam int CFG_W = 4;

   // register port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_LEVELS_IN_USE = 1'b0;
   localparam logic [CFG_W-1:0] LEVELS_IN_USE_RESET = 4'd8;

   typedef enum logic {
      OP_ENQ = 1'b0,
      OP_DEQ = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ST_ENQ    = 3'd0,
      ST_DEQ    = 3'd1,
      ST_EMPTY  = 3'd2,
      ST_REJECT = 3'd3,
      ST_FULL   = 3'd4
   } status_type;

   // access to the entry memory
   typedef struct packed {
      logic              wr_en;
      logic              rd_en;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] wdata;
   } mem_req_type;

endpackage

// File: design/spmf_entry_ram.sv
// entry storage for all levels, one write or one read per cycle
// depends on spmf_pkg for widths and the access struct
module spmf_entry_ram (
   input  logic                          clock,
   input  spmf_pkg::mem_req_type         mem_req,
   output logic [spmf_pkg::DATA_W-1:0]   rd_data
);

   logic [spmf_pkg::DATA_W-1:0] mem [spmf_pkg::LEVELS*spmf_pkg::DEPTH];
   logic [spmf_pkg::DATA_W-1:0] rd_data_ff;

   // synchronous write and registered read
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.addr] <= mem_req.wdata;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/spmf_level_ctrl.sv
// per-level head and fill count, level selection and entry memory addressing
// depends on spmf_pkg
module spmf_level_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  spmf_pkg::op_type              op,
   input  logic [spmf_pkg::DATA_W-1:0]   value,
   input  logic [spmf_pkg::PRI_W-1:0]    priority_req,
   input  logic [spmf_pkg::CFG_W-1:0]    levels_in_use,
   output spmf_pkg::mem_req_type         mem_req,
   output spmf_pkg::status_type          status
);

   localparam int SUM_W = spmf_pkg::PTR_W + 1;

   logic [spmf_pkg::PTR_W-1:0] head_ff [spmf_pkg::LEVELS];
   logic [spmf_pkg::PTR_W-1:0] head_in [spmf_pkg::LEVELS];
   logic [spmf_pkg::CNT_W-1:0] count_ff [spmf_pkg::LEVELS];
   logic [spmf_pkg::CNT_W-1:0] count_in [spmf_pkg::LEVELS];

   logic                       pri_ok;
   logic [spmf_pkg::LVL_W-1:0] pri_lvl;
   logic                       enq_full;
   logic [SUM_W-1:0]           tail_sum;
   logic [spmf_pkg::PTR_W-1:0] tail;
   logic                       deq_found;
   logic [spmf_pkg::LVL_W-1:0] deq_lvl;
   logic [spmf_pkg::PTR_W-1:0] deq_head;

   // enqueue checks and tail position
   always_comb begin
      pri_ok = (32'(priority_req) < 32'(levels_in_use)) &&
               (32'(priority_req) < spmf_pkg::LEVELS);
      pri_lvl = priority_req[spmf_pkg::LVL_W-1:0];
      enq_full = pri_ok && (count_ff[pri_lvl] == spmf_pkg::CNT_W'(spmf_pkg::DEPTH));
      tail_sum = pri_ok ? (SUM_W'(head_ff[pri_lvl]) + SUM_W'(count_ff[pri_lvl])) : '0;
      if (32'(tail_sum) >= spmf_pkg::DEPTH) begin
         tail = spmf_pkg::PTR_W'(32'(tail_sum) - spmf_pkg::DEPTH);
      end else begin
         tail = tail_sum[spmf_pkg::PTR_W-1:0];
      end
   end

   // priority encoder: lowest nonempty level in use
   always_comb begin
      deq_found = 1'b0;
      deq_lvl = '0;
      for (int i = spmf_pkg::LEVELS - 1; i >= 0; i--) begin
         if ((count_ff[i] != '0) && (i < 32'(levels_in_use))) begin
            deq_found = 1'b1;
            deq_lvl = spmf_pkg::LVL_W'(i);
         end
      end
      deq_head = head_ff[deq_lvl];
   end

   // result code, memory access and level state update
   always_comb begin
      mem_req.wr_en = 1'b0;
      mem_req.rd_en = 1'b0;
      mem_req.wdata = value;
      mem_req.addr = '0;
      for (int i = 0; i < spmf_pkg::LEVELS; i++) begin
         head_in[i] = head_ff[i];
         count_in[i] = count_ff[i];
      end
      unique case (op)
         spmf_pkg::OP_ENQ: begin
            mem_req.addr = spmf_pkg::ADDR_W'(32'(pri_lvl) * spmf_pkg::DEPTH + 32'(tail));
            if (!pri_ok) begin
               status = spmf_pkg::ST_REJECT;
            end else if (enq_full) begin
               status = spmf_pkg::ST_FULL;
            end else begin
               status = spmf_pkg::ST_ENQ;
               mem_req.wr_en = accept;
               if (accept) begin
                  count_in[pri_lvl] = count_ff[pri_lvl] + 1'b1;
               end
            end
         end
         spmf_pkg::OP_DEQ: begin
            mem_req.addr = spmf_pkg::ADDR_W'(32'(deq_lvl) * spmf_pkg::DEPTH + 32'(deq_head));
            if (deq_found) begin
               status = spmf_pkg::ST_DEQ;
               mem_req.rd_en = accept;
               if (accept) begin
                  count_in[deq_lvl] = count_ff[deq_lvl] - 1'b1;
                  if (deq_head == spmf_pkg::PTR_W'(spmf_pkg::DEPTH - 1)) begin
                     head_in[deq_lvl] = '0;
                  end else begin
                     head_in[deq_lvl] = deq_head + 1'b1;
                  end
               end
            end else begin
               status = spmf_pkg::ST_EMPTY;
            end
         end
         default: begin
            status = spmf_pkg::ST_EMPTY;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < spmf_pkg::LEVELS; i++) begin
            head_ff[i] <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < spmf_pkg::LEVELS; i++) begin
            head_ff[i] <= head_in[i];
            count_ff[i] <= count_in[i];
         end
      end
   end

endmodule

// File: design/strict_priority_multi_fifo_top.sv
// Strict-priority queue with one FIFO of DEPTH words per level, level 0 most
// urgent. Every transaction on the request channel gives exactly one response.
// Enqueues, rejected or full enqueues and dequeues that find every level empty
// reach the output register in the cycle after they are taken; a successful
// dequeue passes the registered entry memory read first. The response sits in
// an output register, so a new request is taken while the previous response
// is being taken downstream. levels_in_use lies at register address 0.
//
// top level: register port, request/response handshake and output register
// depends on spmf_pkg, spmf_level_ctrl and spmf_entry_ram
module strict_priority_multi_fifo_top (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_op,
   input  logic signed [spmf_pkg::DATA_W-1:0] req_value,
   input  logic [spmf_pkg::PRI_W-1:0]        req_priority_req,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [2:0]                        rsp_status,
   output logic signed [spmf_pkg::DATA_W-1:0] rsp_data_out,
   // register port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [spmf_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [spmf_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [spmf_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   logic [spmf_pkg::CFG_W-1:0]  levels_in_use_ff;
   logic [spmf_pkg::CFG_W-1:0]  levels_in_use_in;
   logic                        pending_ff;
   logic                        pending_in;
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   spmf_pkg::status_type        rsp_status_ff;
   spmf_pkg::status_type        rsp_status_in;
   logic [spmf_pkg::DATA_W-1:0] rsp_data_ff;
   logic [spmf_pkg::DATA_W-1:0] rsp_data_in;

   logic                        rsp_free;
   logic                        accept;
   logic                        reg_sel;
   spmf_pkg::op_type            op;
   spmf_pkg::status_type        status;
   spmf_pkg::mem_req_type       mem_req;
   logic [spmf_pkg::DATA_W-1:0] rd_data;

   // register port
   assign csr_pready = 1'b1;
   assign reg_sel = (csr_paddr[2] == spmf_pkg::REG_LEVELS_IN_USE);

   always_comb begin
      levels_in_use_in = levels_in_use_ff;
      if (csr_psel && csr_penable && csr_pwrite && reg_sel) begin
         levels_in_use_in = csr_pwdata[spmf_pkg::CFG_W-1:0];
      end
      csr_prdata = '0;
      if (reg_sel) begin
         csr_prdata = spmf_pkg::CSR_DATA_W'(levels_in_use_ff);
      end
   end

   // handshake: one dequeue read in flight at most, output register must free up
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = pending_ff || !rsp_free;
   assign accept = req_valid && !req_stall;
   assign op = spmf_pkg::op_type'(req_op);

   spmf_level_ctrl u_level_ctrl (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .op            (op),
      .value         (req_value),
      .priority_req  (req_priority_req),
      .levels_in_use (levels_in_use_ff),
      .mem_req       (mem_req),
      .status        (status)
   );

   spmf_entry_ram u_entry_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   // output register and read-in-flight tracking
   always_comb begin
      pending_in = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_data_in = rsp_data_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (pending_ff) begin
         rsp_valid_in = 1'b1;
         rsp_status_in = spmf_pkg::ST_DEQ;
         rsp_data_in = rd_data;
      end else if (accept) begin
         if (status == spmf_pkg::ST_DEQ) begin
            pending_in = 1'b1;
         end else begin
            rsp_valid_in = 1'b1;
            rsp_status_in = status;
            rsp_data_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         levels_in_use_ff <= spmf_pkg::LEVELS_IN_USE_RESET;
         pending_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         levels_in_use_ff <= levels_in_use_in;
         pending_ff <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_data_out = rsp_data_ff;

endmodule

// File: tb/strict_priority_multi_fifo_top_test.sv
// self-checking testbench for the strict-priority multi-level queue
// holds its own predictor of the per-level FIFOs; depends on spmf_pkg and the top level
`timescale 1ns / 100ps

module strict_priority_multi_fifo_top_test;
   import spmf_pkg::*;

   localparam int IDLE_PCT = 29;
   localparam int HOLD_CYCLES = 60;
   localparam int SETTLE_CYCLES = 6;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam logic [CSR_ADDR_W-1:0] LEVELS_ADDR = CSR_ADDR_W'(4 * int'(REG_LEVELS_IN_USE));
   localparam logic [CSR_ADDR_W-1:0] UNUSED_ADDR = CSR_ADDR_W'(4);

   typedef struct {
      op_type            op;
      logic [DATA_W-1:0] word;
      logic [PRI_W-1:0]  lvl;
   } request_type;

   typedef struct {
      status_type        status;
      logic [DATA_W-1:0] data;
   } reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic                    req_op = 1'b0;
   logic [DATA_W-1:0]       req_value = '0;
   logic [PRI_W-1:0]        req_priority_req = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [2:0]              rsp_status;
   logic [DATA_W-1:0]       rsp_data_out;
   logic                    csr_psel = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]   csr_paddr = '0;
   logic [CSR_DATA_W-1:0]   csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]   csr_prdata;
   logic                    csr_pready;

   // stimulus and expectation stores
   request_type queued_requests[$];
   reply_type   awaited_replies[$];

   // predicted queue contents and register
   logic [DATA_W-1:0] slot_word[LEVELS][DEPTH];
   int unsigned       slot_head[LEVELS];
   int unsigned       slot_fill[LEVELS];
   logic [CFG_W-1:0]  levels_setting = LEVELS_IN_USE_RESET;

   bit          req_taken = 1'b0;
   bit          gaps_on = 1'b1;
   int unsigned hold_asked = 0;
   int unsigned hold_served = 0;
   int unsigned hold_left = 0;
   int unsigned idle_cycles = 0;
   int unsigned failures = 0;
   int unsigned accepted_requests = 0;
   int unsigned settings_tried = 1;
   int unsigned status_seen[5] = '{default: 0};

   strict_priority_multi_fifo_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_value        (req_value),
      .req_priority_req (req_priority_req),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_data_out     (rsp_data_out),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predicted outcome of one request, updating the level FIFOs
   function automatic reply_type serve_request(op_type op, logic [DATA_W-1:0] word,
                                               logic [PRI_W-1:0] lvl);
      reply_type   r;
      int unsigned active;
      int unsigned tail;
      active = (levels_setting > LEVELS) ? LEVELS : levels_setting;
      r.data = '0;
      if (op == OP_ENQ) begin
         if (lvl >= active) begin
            r.status = ST_REJECT;
         end else if (slot_fill[lvl] >= DEPTH) begin
            r.status = ST_FULL;
         end else begin
            tail = (slot_head[lvl] + slot_fill[lvl]) % DEPTH;
            slot_word[lvl][tail] = word;
            slot_fill[lvl]++;
            r.status = ST_ENQ;
         end
      end else begin
         r.status = ST_EMPTY;
         for (int i = 0; i < active; i++) begin
            if (slot_fill[i] != 0) begin
               r.data = slot_word[i][slot_head[i]];
               slot_head[i] = (slot_head[i] + 1) % DEPTH;
               slot_fill[i]--;
               r.status = ST_DEQ;
               break;
            end
         end
      end
      return r;
   endfunction

   // request driver, fed from the pending queue
   always @(negedge clock) begin
      request_type next_req;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (queued_requests.size() != 0 &&
             !(gaps_on && $urandom_range(0, 99) < IDLE_PCT)) begin
            next_req = queued_requests.pop_front();
            req_valid <= 1'b1;
            req_op <= next_req.op;
            req_value <= next_req.word;
            req_priority_req <= next_req.lvl;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response stall: random gaps, plus long hold-offs on request
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_asked != hold_served) begin
         hold_served++;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (gaps_on) begin
         rsp_stall <= ($urandom_range(0, 99) < IDLE_PCT);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // prediction on accepted requests, checking of accepted responses, watchdog
   always @(posedge clock) begin
      reply_type oldest;
      bit        took_req;
      bit        took_rsp;
      took_req = !reset && req_valid && req_stall === 1'b0;
      took_rsp = !reset && rsp_valid === 1'b1 && !rsp_stall;
      req_taken <= took_req;
      if (took_req) begin
         awaited_replies.push_back(serve_request(op_type'(req_op), req_value,
                                                 req_priority_req));
         accepted_requests++;
      end
      if (took_rsp) begin
         if (awaited_replies.size() == 0) begin
            $error("response with nothing expected: status %0d data_out %0d",
                   rsp_status, $signed(rsp_data_out));
            failures++;
         end else begin
            oldest = awaited_replies.pop_front();
            status_seen[oldest.status]++;
            if (rsp_status !== oldest.status) begin
               $error("status: expected %0d actual %0d", oldest.status, rsp_status);
               failures++;
            end
            if (rsp_data_out !== oldest.data) begin
               $error("data_out: expected %0d actual %0d",
                      $signed(oldest.data), $signed(rsp_data_out));
               failures++;
            end
         end
      end
      if (took_req || took_rsp || reset) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", idle_cycles);
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic push_request(op_type op, logic [DATA_W-1:0] word, logic [PRI_W-1:0] lvl);
      request_type r;
      r.op = op;
      r.word = word;
      r.lvl = lvl;
      queued_requests.push_back(r);
   endtask

   // mostly random words, now and then a corner value
   function automatic logic [DATA_W-1:0] random_word();
      logic [DATA_W-1:0] corners[4];
      corners = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
      if ($urandom_range(0, 7) == 0) return corners[$urandom_range(0, 3)];
      return $urandom;
   endfunction

   // mostly a level in use, sometimes any priority
   function automatic logic [PRI_W-1:0] pick_level();
      int unsigned span;
      span = (levels_setting > LEVELS) ? LEVELS : levels_setting;
      if (span == 0 || $urandom_range(0, 99) < 12) return PRI_W'($urandom_range(0, 255));
      return PRI_W'($urandom_range(0, span - 1));
   endfunction

   // runs of enqueues to one level, runs of dequeues, mixed runs and noise
   task automatic plan_phase(int unsigned count);
      int unsigned added;
      int unsigned run_len;
      int unsigned kind;
      logic [PRI_W-1:0] lvl;
      added = 0;
      while (added < count) begin
         kind = $urandom_range(0, 9);
         run_len = $urandom_range(1, 20);
         lvl = pick_level();
         for (int k = 0; k < run_len; k++) begin
            case (kind)
               0, 1, 2, 3: begin
                  push_request(OP_ENQ, random_word(), lvl);
               end
               4, 5, 6: begin
                  push_request(OP_DEQ, $urandom, PRI_W'($urandom_range(0, 255)));
               end
               7, 8: begin
                  push_request(op_type'($urandom_range(0, 1)), random_word(), pick_level());
               end
               default: begin
                  push_request(op_type'($urandom_range(0, 1)), $urandom,
                               PRI_W'($urandom_range(0, 255)));
               end
            endcase
         end
         added += run_len;
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (queued_requests.size() != 0 || req_valid || awaited_replies.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic run_phase(int unsigned count, bit with_gaps, bit with_hold);
      gaps_on = with_gaps;
      plan_phase(count);
      if (with_hold) hold_asked++;
      wait_drained();
   endtask

   task automatic csr_access(logic write, logic [CSR_ADDR_W-1:0] addr,
                             logic [CSR_DATA_W-1:0] wdata, output logic [CSR_DATA_W-1:0] rdata);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= write;
      csr_paddr <= addr;
      csr_pwdata <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock);
      while (csr_pready !== 1'b1);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // read back levels_in_use and compare with the predicted register
   task automatic check_levels_readback();
      logic [CSR_DATA_W-1:0] rdata;
      csr_access(1'b0, LEVELS_ADDR, '0, rdata);
      if (rdata !== CSR_DATA_W'(levels_setting)) begin
         $error("levels_in_use readback: expected %0d actual %0d", levels_setting, rdata);
         failures++;
      end
   endtask

   task automatic set_levels(logic [CFG_W-1:0] count);
      logic [CSR_DATA_W-1:0] rdata;
      csr_access(1'b1, LEVELS_ADDR, {CSR_DATA_W'($urandom) >> CFG_W << CFG_W} | count, rdata);
      levels_setting = count;
      settings_tried++;
      check_levels_readback();
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] rdata;
      for (int i = 0; i < LEVELS; i++) begin
         slot_head[i] = 0;
         slot_fill[i] = 0;
      end
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty queue, extreme words and priorities, urgency order
      push_request(OP_DEQ, 32'h0, 8'd0);
      push_request(OP_ENQ, 32'h7FFF_FFFF, 8'd0);
      push_request(OP_ENQ, 32'h8000_0000, 8'(LEVELS - 1));
      push_request(OP_ENQ, 32'hFFFF_FFFF, 8'd3);
      push_request(OP_ENQ, 32'h0000_0000, 8'd1);
      push_request(OP_ENQ, 32'h1234_5678, 8'(LEVELS));
      push_request(OP_ENQ, 32'hDEAD_BEEF, 8'd255);
      push_request(OP_DEQ, 32'hFFFF_FFFF, 8'd255);
      push_request(OP_DEQ, 32'h0, 8'd0);
      push_request(OP_DEQ, 32'h0, 8'd0);
      push_request(OP_DEQ, 32'h0, 8'd0);
      push_request(OP_DEQ, 32'h0, 8'd0);
      gaps_on = 1'b1;
      wait_drained();
      check_levels_readback();

      // reset setting with a long response hold-off
      run_phase(150, 1'b1, 1'b1);
      // single level
      set_levels(4'd1);
      run_phase(150, 1'b1, 1'b0);
      // no levels: every enqueue rejected, every dequeue empty
      set_levels(4'd0);
      run_phase(40, 1'b1, 1'b0);
      // above the level count, saturates; no random gaps, but a long response hold-off
      set_levels(4'd15);
      run_phase(150, 1'b0, 1'b1);
      // lowered count hides the upper levels, then raised again
      set_levels(4'd3);
      run_phase(120, 1'b1, 1'b0);
      set_levels(4'(LEVELS));
      run_phase(150, 1'b1, 1'b0);

      // write to an address with no register leaves levels_in_use alone
      csr_access(1'b1, UNUSED_ADDR, 32'h0000_0002, rdata);
      check_levels_readback();

      for (int p = 0; p < 5; p++) begin
         set_levels(4'($urandom_range(0, 15)));
         run_phase(150, 1'b1, p == 2);
      end

      $display("covered %0d requests under %0d levels_in_use settings",
               accepted_requests, settings_tried);
      $display("responses: %0d enqueued, %0d dequeued, %0d empty, %0d rejected, %0d full",
               status_seen[ST_ENQ], status_seen[ST_DEQ], status_seen[ST_EMPTY],
               status_seen[ST_REJECT], status_seen[ST_FULL]);
      if (failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// File: filelist.f
design/spmf_pkg.sv
design/spmf_entry_ram.sv
design/spmf_level_ctrl.sv
design/strict_priority_multi_fifo_top.sv
tb/strict_priority_multi_fifo_top_test.sv
